/* rtl/trace_event_nesting_tracker_macros.svh */
// assertion macros used by the checker file
`ifndef TRACE_EVENT_NESTING_TRACKER_MACROS_SVH
`define TRACE_EVENT_NESTING_TRACKER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TENT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define TENT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tent_pkg.sv */
// ----------------------------------------------------------------------------
// tent_pkg
// Shared constants, codes and control types of the trace event nesting
// tracker.
// ----------------------------------------------------------------------------
package tent_pkg;

  // sizes
  localparam int THREAD_SLOTS = 8;
  localparam int SLOT_W       = $clog2(THREAD_SLOTS);
  localparam int STACK_DEPTH  = 16;
  localparam int LVL_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH    = THREAD_SLOTS * STACK_DEPTH;
  localparam int ADDR_W       = SLOT_W + LVL_W;
  localparam int TIME_W       = 63;
  localparam int DEPTH_W      = 5;
  localparam int IN_SLOT_W    = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END   = 2'd1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_POP    = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic pop_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_done;
  } dp_sts_t;

endpackage

/* rtl/tent_ctrl.sv */
// ----------------------------------------------------------------------------
// tent_ctrl
// Sequencer: capture an event, walk the thread stack one level per cycle,
// then commit the update and load the result register.
// ----------------------------------------------------------------------------
module tent_ctrl import tent_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd,
  input  dp_sts_t   sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // commit only when the result register is free or being emptied
  assign commit = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd.capture  = (state_r == ST_IDLE) && in_valid;
    cmd.pop_step = (state_r == ST_POP);
    cmd.commit   = commit;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.pop_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/tent_dp.sv */
// ----------------------------------------------------------------------------
// tent_dp
// Datapath: frame registers, per-thread stack memory and totals, pop
// compare, busy-time accumulator and the result register.
// ----------------------------------------------------------------------------
module tent_dp import tent_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic [IN_SLOT_W-1:0] in_thread_slot,
  input  logic [TIME_W-1:0]    in_event_start,
  input  logic [TIME_W-1:0]    in_event_end,
  input  logic                 in_is_vsync,
  output logic [DEPTH_W-1:0]   out_nest_depth,
  output logic                 out_stack_overflow,
  output logic [TIME_W-1:0]    out_used_start,
  output logic [TIME_W-1:0]    out_used_end,
  output logic [DEPTH_W-1:0]   out_thread_max_depth,
  output logic [TIME_W-1:0]    out_thread_first_start,
  output logic [TIME_W-1:0]    out_thread_last_end,
  output logic [TIME_W-1:0]    out_thread_busy_time
);

  // frame registers
  logic [TIME_W-1:0] frame_start_r, frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= '0;
      frame_end_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_START: frame_start_r <= cfg_data;
        CFG_FRAME_END:   frame_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-thread state
  logic [CNT_W-1:0]   cnt_r   [THREAD_SLOTS];
  logic [DEPTH_W-1:0] deep_r  [THREAD_SLOTS];
  logic [TIME_W-1:0]  first_r [THREAD_SLOTS];
  logic [TIME_W-1:0]  last_r  [THREAD_SLOTS];
  logic [TIME_W-1:0]  busy_r  [THREAD_SLOTS];
  logic               seen_r  [THREAD_SLOTS];

  // current transaction
  logic [SLOT_W-1:0] t_r;
  logic [TIME_W-1:0] s_r, e_r, dur_r;
  logic              vsync_r, pos_r;
  logic [CNT_W-1:0]  n_r;
  logic [SLOT_W-1:0] slot_in;

  assign slot_in = in_thread_slot[SLOT_W-1:0];

  // stack memory and its read port
  logic [TIME_W-1:0] stack_mem [MEM_DEPTH];
  logic [TIME_W-1:0] rd_data_r;
  logic [CNT_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en, stack_full;

  always_comb begin
    if (cmd.capture) begin
      rd_idx  = cnt_r[slot_in] - CNT_W'(1);
      rd_addr = {slot_in, rd_idx[LVL_W-1:0]};
    end else begin
      rd_idx  = n_r - CNT_W'(2);
      rd_addr = {t_r, rd_idx[LVL_W-1:0]};
    end
  end

  assign stack_full = (n_r == CNT_W'(STACK_DEPTH));
  assign wr_en      = cmd.commit && !stack_full;
  assign wr_addr    = {t_r, n_r[LVL_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= e_r;
    rd_data_r <= stack_mem[rd_addr];
  end

  // pop compare against the top entry read last cycle
  logic pop_hit;
  assign pop_hit      = (n_r != '0) && (s_r >= rd_data_r);
  assign sts.pop_done = !pop_hit;

  // capture with normalization, pop walk, duration precompute
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r     <= slot_in;
      s_r     <= (in_event_start == '0) ? frame_start_r : in_event_start;
      e_r     <= (in_event_end == '0) ? frame_end_r : in_event_end;
      vsync_r <= in_is_vsync;
      n_r     <= cnt_r[slot_in];
    end else if (cmd.pop_step) begin
      if (pop_hit) n_r <= n_r - CNT_W'(1);
      dur_r <= e_r - s_r;
      pos_r <= e_r > s_r;
    end
  end

  // commit values for the selected thread
  logic [DEPTH_W-1:0] depth, deep_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [TIME_W-1:0]  first_nxt, last_nxt, busy_nxt;
  logic [TIME_W:0]    busy_sum;

  always_comb begin
    depth     = DEPTH_W'(n_r);
    deep_nxt  = (depth > deep_r[t_r]) ? depth : deep_r[t_r];
    cnt_nxt   = stack_full ? n_r : n_r + CNT_W'(1);
    first_nxt = (!seen_r[t_r] || s_r < first_r[t_r]) ? s_r : first_r[t_r];
    last_nxt  = (e_r > last_r[t_r]) ? e_r : last_r[t_r];
    busy_sum  = {1'b0, busy_r[t_r]} + {1'b0, dur_r};
    busy_nxt  = busy_r[t_r];
    if (!vsync_r && (n_r == '0) && pos_r)
      busy_nxt = busy_sum[TIME_W] ? {TIME_W{1'b1}} : busy_sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        cnt_r[i]   <= '0;
        deep_r[i]  <= '0;
        first_r[i] <= '0;
        last_r[i]  <= '0;
        busy_r[i]  <= '0;
        seen_r[i]  <= 1'b0;
      end
    end else if (cmd.commit) begin
      cnt_r[t_r]   <= cnt_nxt;
      deep_r[t_r]  <= deep_nxt;
      first_r[t_r] <= first_nxt;
      last_r[t_r]  <= last_nxt;
      busy_r[t_r]  <= busy_nxt;
      seen_r[t_r]  <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_nest_depth         <= depth;
      out_stack_overflow     <= stack_full;
      out_used_start         <= s_r;
      out_used_end           <= e_r;
      out_thread_max_depth   <= deep_nxt;
      out_thread_first_start <= first_nxt;
      out_thread_last_end    <= last_nxt;
      out_thread_busy_time   <= busy_nxt;
    end
  end

endmodule

/* rtl/trace_event_nesting_tracker.sv */
// ----------------------------------------------------------------------------
// trace_event_nesting_tracker
// Per-thread nesting depth, time bounds and busy time of trace events.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall   | slot, start, end, vsync
//   out_    | output    | out_valid/out_stall | depth, overflow, times, totals
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// From acceptance, an event walks its thread stack and pops the entries
// that end at or before its start: the walk reads one stack level per
// cycle from the stack memory. One event is in work at a time.
// The result register frees the front end: a new event is taken while a
// result waits; a stalled result holds only the final commit step.
// Synchronous reset clears all per-thread totals and counts; the stack
// memory needs no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module trace_event_nesting_tracker import tent_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_SLOT_W-1:0] in_thread_slot,
  input  logic [TIME_W-1:0]    in_event_start,
  input  logic [TIME_W-1:0]    in_event_end,
  input  logic                 in_is_vsync,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DEPTH_W-1:0]   out_nest_depth,
  output logic                 out_stack_overflow,
  output logic [TIME_W-1:0]    out_used_start,
  output logic [TIME_W-1:0]    out_used_end,
  output logic [DEPTH_W-1:0]   out_thread_max_depth,
  output logic [TIME_W-1:0]    out_thread_first_start,
  output logic [TIME_W-1:0]    out_thread_last_end,
  output logic [TIME_W-1:0]    out_thread_busy_time
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  tent_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tent_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_thread_slot         (in_thread_slot),
    .in_event_start         (in_event_start),
    .in_event_end           (in_event_end),
    .in_is_vsync            (in_is_vsync),
    .out_nest_depth         (out_nest_depth),
    .out_stack_overflow     (out_stack_overflow),
    .out_used_start         (out_used_start),
    .out_used_end           (out_used_end),
    .out_thread_max_depth   (out_thread_max_depth),
    .out_thread_first_start (out_thread_first_start),
    .out_thread_last_end    (out_thread_last_end),
    .out_thread_busy_time   (out_thread_busy_time)
  );

endmodule

/* rtl/tent_checker.sv */
// ----------------------------------------------------------------------------
// tent_checker
// Port-level checks of the trace event nesting tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "trace_event_nesting_tracker_macros.svh"

module tent_checker import tent_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DEPTH_W-1:0] out_nest_depth,
  input logic               out_stack_overflow,
  input logic [TIME_W-1:0]  out_used_start,
  input logic [TIME_W-1:0]  out_used_end,
  input logic [DEPTH_W-1:0] out_thread_max_depth,
  input logic [TIME_W-1:0]  out_thread_first_start,
  input logic [TIME_W-1:0]  out_thread_last_end
);

  // a stalled result transaction stays offered
  `TENT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // depth never exceeds the stack size
  `TENT_ASSERT_NOW(a_depth_range, clk, rst_n, out_valid, out_nest_depth <= DEPTH_W'(STACK_DEPTH), "depth beyond stack size")

  // overflow only on a full stack
  `TENT_ASSERT_NOW(a_ovf_full, clk, rst_n, out_valid && out_stack_overflow, out_nest_depth == DEPTH_W'(STACK_DEPTH), "overflow without full stack")

  // thread maximum covers this depth
  `TENT_ASSERT_NOW(a_max_depth, clk, rst_n, out_valid, out_thread_max_depth >= out_nest_depth, "max depth below event depth")

  // thread bounds enclose the event times
  `TENT_ASSERT_NOW(a_bounds, clk, rst_n, out_valid, (out_thread_first_start <= out_used_start) && (out_thread_last_end >= out_used_end), "thread bounds miss event")

endmodule

bind trace_event_nesting_tracker tent_checker u_tent_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_nest_depth         (out_nest_depth),
  .out_stack_overflow     (out_stack_overflow),
  .out_used_start         (out_used_start),
  .out_used_end           (out_used_end),
  .out_thread_max_depth   (out_thread_max_depth),
  .out_thread_first_start (out_thread_first_start),
  .out_thread_last_end    (out_thread_last_end)
);
